FILE: design/dpbp_pkg.sv
// shared constants and types of the depth pixel back-projector
`default_nettype none

package dpbp_pkg;

    localparam int CoordWidth = 12;
    localparam int CoordBits  = (CoordWidth < 12) ? CoordWidth : 12;
    localparam int CmpBits    = ((CoordBits > 8) ? CoordBits : 8) + 1;

    localparam int DivStages = 4;
    localparam int DivSteps  = (CoordBits + DivStages - 1) / DivStages;
    localparam int DivBits   = DivStages * DivSteps;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] RegWindow = 3'd0;
    localparam logic [CfgIdxW-1:0] RegIScale = 3'd1;
    localparam logic [CfgIdxW-1:0] RegFocal  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCenter = 3'd3;
    localparam logic [CfgIdxW-1:0] RegRotX   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegRotY   = 3'd5;
    localparam logic [CfgIdxW-1:0] RegRotZ   = 3'd6;
    localparam logic [CfgIdxW-1:0] RegTrans  = 3'd7;

    typedef struct packed {
        logic [7:0]         rem_u;
        logic [7:0]         rem_v;
        logic [DivBits-1:0] num_u;
        logic [DivBits-1:0] num_v;
    } t_grid;

endpackage

`default_nettype wire

FILE: design/dpbp_ifs.sv
// pixel input and world point output channel interfaces
`default_nettype none

interface dpbp_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [15:0] raw_depth;

    modport source (output valid, pixel_col, pixel_row, raw_depth, input ready);
    modport sink   (input valid, pixel_col, pixel_row, raw_depth, output ready);
endinterface

interface dpbp_pt_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] world_x;
    logic signed [19:0] world_y;
    logic signed [19:0] world_z;
    logic               is_miss;
    logic [11:0]        source_col;
    logic [11:0]        source_row;

    modport source (output valid, world_x, world_y, world_z, is_miss, source_col,
                    source_row, input ready);
    modport sink   (input valid, world_x, world_y, world_z, is_miss, source_col,
                    source_row, output ready);
endinterface

`default_nettype wire

FILE: design/dpbp_grid_stage.sv
// one registered stage of the sampling grid remainder computation
`default_nettype none

module dpbp_grid_stage (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [7:0]    i_step,
    input  wire dpbp_pkg::t_grid i_grid,
    output dpbp_pkg::t_grid    o_grid
);

    dpbp_pkg::t_grid r_grid;
    dpbp_pkg::t_grid n_grid;
    logic [8:0]      sum_u;
    logic [8:0]      sum_v;

    // restoring remainder, one dividend bit per step
    always_comb begin
        n_grid = i_grid;
        sum_u  = '0;
        sum_v  = '0;
        for (int k = 0; k < dpbp_pkg::DivSteps; k++) begin
            sum_u = {n_grid.rem_u, n_grid.num_u[dpbp_pkg::DivBits-1]};
            if (sum_u >= {1'b0, i_step}) begin
                sum_u = sum_u - {1'b0, i_step};
            end
            sum_v = {n_grid.rem_v, n_grid.num_v[dpbp_pkg::DivBits-1]};
            if (sum_v >= {1'b0, i_step}) begin
                sum_v = sum_v - {1'b0, i_step};
            end
            n_grid.rem_u = sum_u[7:0];
            n_grid.rem_v = sum_v[7:0];
            n_grid.num_u = n_grid.num_u << 1;
            n_grid.num_v = n_grid.num_v << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grid <= n_grid;
        end
    end

    assign o_grid = r_grid;

endmodule

`default_nettype wire

FILE: design/depth_pixel_backprojector_top.sv
// depth pixel back-projector: pixel stream in, world point stream out
//
// Pixels arrive on i_pix (column, row, raw depth) with a valid/ready
// transaction and leave as world points on o_pt. A pixel off the sampling
// grid, outside the margin window or nearer than the minimum depth yields
// no transaction on o_pt; every other pixel yields exactly one, in order.
// The datapath is a seven stage pipeline: input register with the depth
// scaling multiply, four stages of grid remainder steps that run beside
// depth classification, the two camera frame multiplies and the rotation
// products, then the row sums, and the output register with translation
// and saturation. One pixel can be taken every cycle unless the whole
// pipeline is full and o_pt stalls. When o_pt stalls, the output stage
// holds its point, the other stages advance into empty stages and hold
// once all later stages are full, and i_pix.ready falls only then.
// Synchronous reset empties the pipeline and clears the configuration
// registers to zero. The user writes registers through i_cfg_* only
// while no transaction is in flight; the block does not enforce this.
`default_nettype none

module depth_pixel_backprojector_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dpbp_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  wire logic [dpbp_pkg::CfgDataW-1:0]   i_cfg_data,
    dpbp_pix_if.sink                             i_pix,
    dpbp_pt_if.source                            o_pt
);

    localparam int Cb = dpbp_pkg::CoordBits;
    localparam int Mb = dpbp_pkg::CmpBits;
    localparam int Db = dpbp_pkg::DivBits;

    // configuration registers
    logic [39:0] r_win;
    logic [23:0] r_iscale;
    logic [47:0] r_focal;
    logic [63:0] r_ctr;
    logic [47:0] r_rot_x;
    logic [47:0] r_rot_y;
    logic [47:0] r_rot_z;
    logic [59:0] r_trans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_iscale <= '0;
            r_focal  <= '0;
            r_ctr    <= '0;
            r_rot_x  <= '0;
            r_rot_y  <= '0;
            r_rot_z  <= '0;
            r_trans  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpbp_pkg::RegWindow: r_win    <= i_cfg_data[39:0];
                dpbp_pkg::RegIScale: r_iscale <= i_cfg_data[23:0];
                dpbp_pkg::RegFocal:  r_focal  <= i_cfg_data[47:0];
                dpbp_pkg::RegCenter: r_ctr    <= i_cfg_data;
                dpbp_pkg::RegRotX:   r_rot_x  <= i_cfg_data[47:0];
                dpbp_pkg::RegRotY:   r_rot_y  <= i_cfg_data[47:0];
                dpbp_pkg::RegRotZ:   r_rot_z  <= i_cfg_data[47:0];
                dpbp_pkg::RegTrans:  r_trans  <= i_cfg_data[59:0];
                default: ;
            endcase
        end
    end

    logic [Cb-1:0] img_w;
    logic [Cb-1:0] img_h;
    logic [7:0]    margin;
    logic [7:0]    step;
    logic [15:0]   ctr_x;
    logic [15:0]   ctr_y;
    logic [15:0]   lim_lo;
    logic [15:0]   lim_hi;
    logic [23:0]   rfx;
    logic [23:0]   rfy;

    assign img_w  = r_win[Cb-1:0];
    assign img_h  = r_win[12 +: Cb];
    assign margin = r_win[31:24];
    assign step   = (r_win[39:32] == 8'd0) ? 8'd1 : r_win[39:32];
    assign ctr_x  = r_ctr[15:0];
    assign ctr_y  = r_ctr[31:16];
    assign lim_lo = r_ctr[47:32];
    assign lim_hi = r_ctr[63:48];
    assign rfx    = r_focal[23:0];
    assign rfy    = r_focal[47:24];

    // pipeline flow control
    logic [7:1] r_v;
    logic [7:1] w_en;

    always_comb begin
        w_en[7] = !r_v[7] || o_pt.ready;
        for (int k = 6; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_pix.ready = w_en[1];

    // stage 1: window check, depth scaling, centered pixel offsets
    logic [Cb-1:0]      pix_u;
    logic [Cb-1:0]      pix_v;
    logic [15:0]        ush;
    logic [15:0]        vsh;
    logic [39:0]        exact;
    logic               n_s1_win_ok;
    dpbp_pkg::t_grid    n_s1_grid;

    assign pix_u = i_pix.pixel_col[Cb-1:0];
    assign pix_v = i_pix.pixel_row[Cb-1:0];
    assign ush   = 16'({pix_u, 4'b0000});
    assign vsh   = 16'({pix_v, 4'b0000});
    assign exact = i_pix.raw_depth * r_iscale;

    always_comb begin
        n_s1_win_ok = (Mb'(pix_u) >= Mb'(margin))
                   && (Mb'(pix_u) + Mb'(margin) < Mb'(img_w))
                   && (Mb'(pix_v) >= Mb'(margin))
                   && (Mb'(pix_v) + Mb'(margin) < Mb'(img_h));
        n_s1_grid.rem_u = '0;
        n_s1_grid.rem_v = '0;
        n_s1_grid.num_u = Db'(Mb'(pix_u) - Mb'(margin));
        n_s1_grid.num_v = Db'(Mb'(pix_v) - Mb'(margin));
    end

    logic [Cb-1:0]      r_s1_u;
    logic [Cb-1:0]      r_s1_v;
    logic               r_s1_zero;
    logic [39:0]        r_s1_exact;
    logic signed [16:0] r_s1_du;
    logic signed [16:0] r_s1_dv;
    logic               r_s1_win_ok;
    dpbp_pkg::t_grid    r_s1_grid;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_u      <= pix_u;
            r_s1_v      <= pix_v;
            r_s1_zero   <= (i_pix.raw_depth == 16'd0);
            r_s1_exact  <= exact;
            r_s1_du     <= $signed({1'b0, ush}) - $signed({1'b0, ctr_x});
            r_s1_dv     <= $signed({1'b0, vsh}) - $signed({1'b0, ctr_y});
            r_s1_win_ok <= n_s1_win_ok;
            r_s1_grid   <= n_s1_grid;
        end
    end

    // grid remainder stages, loaded with stages 2 to 5
    dpbp_pkg::t_grid w_grid [0:dpbp_pkg::DivStages];

    assign w_grid[0] = r_s1_grid;

    for (genvar g = 0; g < dpbp_pkg::DivStages; g++) begin : g_grid
        dpbp_grid_stage u_grid (
            .i_clk  (i_clk),
            .i_en   (w_en[g+2]),
            .i_step (step),
            .i_grid (w_grid[g]),
            .o_grid (w_grid[g+1])
        );
    end

    // stage 2: depth classification
    logic [39:0] hi_ext;
    logic [39:0] lo_ext;
    logic        clamp;

    assign hi_ext = {8'd0, lim_hi, 16'd0};
    assign lo_ext = {8'd0, lim_lo, 16'd0};
    assign clamp  = r_s1_zero || (r_s1_exact > hi_ext);

    logic [Cb-1:0]      r_s2_u;
    logic [Cb-1:0]      r_s2_v;
    logic signed [16:0] r_s2_du;
    logic signed [16:0] r_s2_dv;
    logic [15:0]        r_s2_dq;
    logic               r_s2_miss;
    logic               r_s2_drop;
    logic               r_s2_win_ok;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_u      <= r_s1_u;
            r_s2_v      <= r_s1_v;
            r_s2_du     <= r_s1_du;
            r_s2_dv     <= r_s1_dv;
            r_s2_dq     <= clamp ? lim_hi : r_s1_exact[31:16];
            r_s2_miss   <= clamp || (r_s1_exact == hi_ext);
            r_s2_drop   <= !clamp && (r_s1_exact < lo_ext);
            r_s2_win_ok <= r_s1_win_ok;
        end
    end

    // stage 3: offset times depth
    logic signed [33:0] prod_x3;
    logic signed [33:0] prod_y3;

    assign prod_x3 = r_s2_du * $signed({1'b0, r_s2_dq});
    assign prod_y3 = r_s2_dv * $signed({1'b0, r_s2_dq});

    logic [Cb-1:0]      r_s3_u;
    logic [Cb-1:0]      r_s3_v;
    logic signed [32:0] r_s3_px;
    logic signed [32:0] r_s3_py;
    logic [15:0]        r_s3_dq;
    logic               r_s3_miss;
    logic               r_s3_drop;
    logic               r_s3_win_ok;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_u      <= r_s2_u;
            r_s3_v      <= r_s2_v;
            r_s3_px     <= prod_x3[32:0];
            r_s3_py     <= prod_y3[32:0];
            r_s3_dq     <= r_s2_dq;
            r_s3_miss   <= r_s2_miss;
            r_s3_drop   <= r_s2_drop;
            r_s3_win_ok <= r_s2_win_ok;
        end
    end

    // stage 4: scale by reciprocal focal lengths into camera frame
    logic signed [57:0] prod_x4;
    logic signed [57:0] prod_y4;

    assign prod_x4 = r_s3_px * $signed({1'b0, rfx});
    assign prod_y4 = r_s3_py * $signed({1'b0, rfy});

    logic [Cb-1:0]      r_s4_u;
    logic [Cb-1:0]      r_s4_v;
    logic signed [36:0] r_s4_cam [3];
    logic               r_s4_miss;
    logic               r_s4_drop;
    logic               r_s4_win_ok;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_u      <= r_s3_u;
            r_s4_v      <= r_s3_v;
            r_s4_cam[0] <= prod_x4[56:20];
            r_s4_cam[1] <= prod_y4[56:20];
            r_s4_cam[2] <= $signed(37'({r_s3_dq, 8'd0}));
            r_s4_miss   <= r_s3_miss;
            r_s4_drop   <= r_s3_drop;
            r_s4_win_ok <= r_s3_win_ok;
        end
    end

    // stage 5: rotation products
    logic signed [15:0] rot [3][3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            rot[0][j] = r_rot_x[16*j +: 16];
            rot[1][j] = r_rot_y[16*j +: 16];
            rot[2][j] = r_rot_z[16*j +: 16];
        end
    end

    logic [Cb-1:0]      r_s5_u;
    logic [Cb-1:0]      r_s5_v;
    logic signed [52:0] r_s5_p [3][3];
    logic               r_s5_miss;
    logic               r_s5_drop;
    logic               r_s5_win_ok;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_u      <= r_s4_u;
            r_s5_v      <= r_s4_v;
            r_s5_miss   <= r_s4_miss;
            r_s5_drop   <= r_s4_drop;
            r_s5_win_ok <= r_s4_win_ok;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_s5_p[i][j] <= rot[i][j] * r_s4_cam[j];
                end
            end
        end
    end

    // stage 6: row sums and the keep decision
    dpbp_pkg::t_grid    grid_done;
    logic               keep5;

    assign grid_done = w_grid[dpbp_pkg::DivStages];
    assign keep5     = r_s5_win_ok && !r_s5_drop
                    && (grid_done.rem_u == 8'd0) && (grid_done.rem_v == 8'd0);

    logic [Cb-1:0]      r_s6_u;
    logic [Cb-1:0]      r_s6_v;
    logic signed [54:0] r_s6_sum [3];
    logic               r_s6_miss;
    logic               r_s6_keep;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s6_u    <= r_s5_u;
            r_s6_v    <= r_s5_v;
            r_s6_miss <= r_s5_miss;
            r_s6_keep <= keep5;
            for (int i = 0; i < 3; i++) begin
                r_s6_sum[i] <= 55'(r_s5_p[i][0]) + 55'(r_s5_p[i][1]) + 55'(r_s5_p[i][2]);
            end
        end
    end

    // stage 7: translation, saturation, output register
    function automatic logic signed [19:0] world_sat(input logic signed [54:0] acc,
                                                      input logic signed [19:0] ofs);
        logic signed [33:0] w;
        w = $signed({acc[54], acc[54:22]}) + $signed({{14{ofs[19]}}, ofs});
        if (w > 34'sd524287) begin
            return 20'sh7FFFF;
        end else if (w < -34'sd524288) begin
            return 20'sh80000;
        end else begin
            return w[19:0];
        end
    endfunction

    logic signed [19:0] r_s7_w [3];
    logic               r_s7_miss;
    logic [Cb-1:0]      r_s7_u;
    logic [Cb-1:0]      r_s7_v;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s7_miss <= r_s6_miss;
            r_s7_u    <= r_s6_u;
            r_s7_v    <= r_s6_v;
            for (int i = 0; i < 3; i++) begin
                r_s7_w[i] <= world_sat(r_s6_sum[i], r_trans[20*i +: 20]);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= i_pix.valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_en[7]) begin
                r_v[7] <= r_v[6] && r_s6_keep;
            end
        end
    end

    assign o_pt.valid      = r_v[7];
    assign o_pt.world_x    = r_s7_w[0];
    assign o_pt.world_y    = r_s7_w[1];
    assign o_pt.world_z    = r_s7_w[2];
    assign o_pt.is_miss    = r_s7_miss;
    assign o_pt.source_col = 12'(r_s7_u);
    assign o_pt.source_row = 12'(r_s7_v);

    // checks
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v == '1 && !o_pt.ready) |-> !i_pix.ready)
        else $error("input taken while pipeline full and output stalled");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_v[1])
        else $error("accepted transaction did not enter stage one");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pt.valid && o_pt.ready && !r_v[6]) |=> !o_pt.valid)
        else $error("output transaction repeated");

endmodule

`default_nettype wire
